@@ sv/lmb_pkg.sv @@
package lmb_pkg;

	// Level format: signed Q8.8 dB
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned HOLD_W  = 8;
	localparam int unsigned COEF_W  = 16;

	typedef logic signed [LEVEL_W-1:0] level_t;
	typedef logic [HOLD_W-1:0]         hold_t;
	typedef logic [COEF_W-1:0]         coef_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_FLOOR_DB         = 2'd0,
		REG_PEAK_HOLD_TICKS  = 2'd1,
		REG_SILENCE_FLOOR_DB = 2'd2,
		REG_UNUSED           = 2'd3
	} reg_index_t;

	// Release coefficients, unsigned Q0.16 (0.15 and 0.18)
	localparam coef_t IN_RELEASE_COEF = 16'd9830;
	localparam coef_t GR_RELEASE_COEF = 16'd11796;

	// Peak decay of 1.5 dB per tick
	localparam level_t PEAK_DECAY_STEP = 16'sd384;

	// Anything above -0.05 dB reads as zero reduction
	localparam level_t SNAP_LIMIT = -16'sd13;

	// Reset values
	localparam level_t LEVEL_RESET            = -16'sd25600;
	localparam level_t FLOOR_DB_RESET         = -16'sd15360;
	localparam hold_t  PEAK_HOLD_TICKS_RESET  = 8'd18;
	localparam level_t SILENCE_FLOOR_DB_RESET = -16'sd12800;

	localparam level_t LEVEL_MAX = 16'sh7FFF;
	localparam level_t LEVEL_MIN = -16'sh8000;

endpackage

@@ sv/lmb_release.sv @@
module lmb_release (
	input  lmb_pkg::level_t cur,
	input  lmb_pkg::level_t target,
	input  lmb_pkg::coef_t  coef,
	output lmb_pkg::level_t next
);

	logic signed [lmb_pkg::LEVEL_W:0]     gap;
	logic signed [lmb_pkg::COEF_W:0]      coef_s;
	logic signed [2*lmb_pkg::LEVEL_W+1:0] prod;
	logic signed [lmb_pkg::LEVEL_W+1:0]   step;
	logic signed [lmb_pkg::LEVEL_W+1:0]   sum;

	// Gap times coefficient, floored by the arithmetic shift
	always_comb begin
		gap    = {target[lmb_pkg::LEVEL_W-1], target} - {cur[lmb_pkg::LEVEL_W-1], cur};
		coef_s = {1'b0, coef};
		prod   = gap * coef_s;
		step   = prod[2*lmb_pkg::LEVEL_W+1:lmb_pkg::COEF_W];
		sum    = {{2{cur[lmb_pkg::LEVEL_W-1]}}, cur} + step;
	end

	// Saturate to the level range
	always_comb begin
		if (sum > 18'(lmb_pkg::LEVEL_MAX)) begin
			next = lmb_pkg::LEVEL_MAX;
		end else if (sum < 18'(lmb_pkg::LEVEL_MIN)) begin
			next = lmb_pkg::LEVEL_MIN;
		end else begin
			next = sum[lmb_pkg::LEVEL_W-1:0];
		end
	end

endmodule

@@ sv/level_meter_ballistics.sv @@
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | input_level_db, reduction_db, engaged
// out     | output    | out_valid / out_ready | shown_input_db, peak_marker_db,
//         |           |                       | shown_reduction_db, silent
// cfg     | input     | cfg_wr_en             | cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an accepted item passes through
// the input register, then the result register holding the updated meter state.
// Meter state updates in the single combinational pass between the two registers.
// A stalled output holds the result and stops the input register; in_ready follows.
// arst_n clears the meter state and loads the configuration reset values.
module level_meter_ballistics (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lmb_pkg::level_t input_level_db,
	input  lmb_pkg::level_t reduction_db,
	input  logic            engaged,
	output logic            out_valid,
	input  logic            out_ready,
	output lmb_pkg::level_t shown_input_db,
	output lmb_pkg::level_t peak_marker_db,
	output lmb_pkg::level_t shown_reduction_db,
	output logic            silent,
	input  logic            cfg_wr_en,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);

	lmb_pkg::level_t floor_db_q;
	lmb_pkg::hold_t  peak_hold_ticks_q;
	lmb_pkg::level_t silence_floor_db_q;

	lmb_pkg::level_t smoothed_input_q;
	lmb_pkg::level_t peak_level_q;
	lmb_pkg::hold_t  hold_count_q;
	lmb_pkg::level_t smoothed_reduction_q;

	logic            valid_s1;
	lmb_pkg::level_t level_s1;
	lmb_pkg::level_t gr_s1;
	logic            engaged_s1;

	logic            valid_s2;
	lmb_pkg::level_t shown_input_s2;
	lmb_pkg::level_t peak_s2;
	lmb_pkg::level_t shown_gr_s2;
	logic            silent_s2;

	logic            advance;
	lmb_pkg::level_t in_release;
	lmb_pkg::level_t gr_release;
	lmb_pkg::level_t input_next;
	lmb_pkg::level_t peak_next;
	lmb_pkg::hold_t  hold_next;
	lmb_pkg::level_t gr_next;
	logic            silent_next;
	logic signed [lmb_pkg::LEVEL_W:0] decay;
	lmb_pkg::level_t decay_sat;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_db_q         <= lmb_pkg::FLOOR_DB_RESET;
			peak_hold_ticks_q  <= lmb_pkg::PEAK_HOLD_TICKS_RESET;
			silence_floor_db_q <= lmb_pkg::SILENCE_FLOOR_DB_RESET;
		end else if (cfg_wr_en) begin
			unique case (lmb_pkg::reg_index_t'(cfg_index))
				lmb_pkg::REG_FLOOR_DB:         floor_db_q         <= cfg_data;
				lmb_pkg::REG_PEAK_HOLD_TICKS:  peak_hold_ticks_q  <= cfg_data[7:0];
				lmb_pkg::REG_SILENCE_FLOOR_DB: silence_floor_db_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1   <= input_level_db;
			gr_s1      <= reduction_db;
			engaged_s1 <= engaged;
		end
	end

	lmb_release u_in_release (
		.cur    (smoothed_input_q),
		.target (level_s1),
		.coef   (lmb_pkg::IN_RELEASE_COEF),
		.next   (in_release)
	);

	lmb_release u_gr_release (
		.cur    (smoothed_reduction_q),
		.target (gr_s1),
		.coef   (lmb_pkg::GR_RELEASE_COEF),
		.next   (gr_release)
	);

	// Input display: instant attack, slow release
	always_comb begin
		input_next = (level_s1 > smoothed_input_q) ? level_s1 : in_release;
	end

	// Peak marker: re-arm on reach, hold, then decay down to the floor
	always_comb begin
		decay     = {peak_level_q[15], peak_level_q} - 17'(lmb_pkg::PEAK_DECAY_STEP);
		decay_sat = (decay < 17'(lmb_pkg::LEVEL_MIN)) ? lmb_pkg::LEVEL_MIN : decay[15:0];
		peak_next = peak_level_q;
		hold_next = hold_count_q;
		priority if (level_s1 >= peak_level_q) begin
			peak_next = level_s1;
			hold_next = peak_hold_ticks_q;
		end else if (hold_count_q != '0) begin
			hold_next = hold_count_q - 8'd1;
		end else begin
			peak_next = (decay_sat > floor_db_q) ? decay_sat : floor_db_q;
		end
	end

	// Gain reduction: gate, instant attack, slow release, snap to zero
	always_comb begin
		silent_next = input_next < silence_floor_db_q;
		priority if (!engaged_s1 || silent_next) begin
			gr_next = '0;
		end else if (gr_s1 < smoothed_reduction_q) begin
			gr_next = gr_s1;
		end else begin
			gr_next = gr_release;
		end
		if (gr_next > lmb_pkg::SNAP_LIMIT) begin
			gr_next = '0;
		end
	end

	// Meter state advances with each item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_input_q     <= lmb_pkg::LEVEL_RESET;
			peak_level_q         <= lmb_pkg::LEVEL_RESET;
			hold_count_q         <= '0;
			smoothed_reduction_q <= '0;
		end else if (advance) begin
			smoothed_input_q     <= input_next;
			peak_level_q         <= peak_next;
			hold_count_q         <= hold_next;
			smoothed_reduction_q <= gr_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			shown_input_s2 <= input_next;
			peak_s2        <= peak_next;
			shown_gr_s2    <= gr_next;
			silent_s2      <= silent_next;
		end
	end

	assign out_valid          = valid_s2;
	assign shown_input_db     = shown_input_s2;
	assign peak_marker_db     = peak_s2;
	assign shown_reduction_db = shown_gr_s2;
	assign silent             = silent_s2;

`ifndef SYNTH
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_s1_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("item stuck in the input register with an empty result register");

	a_reduction_snapped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (shown_gr_s2 == '0 || shown_gr_s2 <= lmb_pkg::SNAP_LIMIT))
		else $error("shown reduction inside the snap band");

	a_silent_gates: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && silent_s2 |-> shown_gr_s2 == '0)
		else $error("reduction shown while silent");
`endif

endmodule
